[sv/rpd_pkg.sv]
// Package with the shared types and constants of the RC PWM channel decoder.
`timescale 1ns / 1ps
package rpd_pkg;

  localparam int unsigned NumChannels = 4;
  localparam int unsigned ChanBits    = 2;
  localparam int unsigned WidthBits   = 16;
  localparam int unsigned SetupBits   = 49;
  localparam int unsigned DzBits      = 15;
  localparam int unsigned CfgIdxBits  = 3;
  localparam int unsigned QuoBits     = 14;
  localparam int unsigned DivCntBits  = 4;

  localparam logic [CfgIdxBits-1:0] CfgIdxDeadZone = 3'd4;

  localparam logic [SetupBits-1:0] SetupReset    = 49'd8590032897000;
  localparam logic [DzBits-1:0]    DeadZoneReset = 15'd819;

  localparam logic [WidthBits-1:0] TripWidth0   = 16'd2011;
  localparam logic [WidthBits-1:0] TripWidth1   = 16'd1506;
  localparam logic [WidthBits-1:0] TripWidth2   = 16'd1500;
  localparam logic [WidthBits-1:0] TripWidth3   = 16'd1561;
  localparam logic [WidthBits-1:0] ReleaseWidth = 16'd1000;

  localparam logic signed [15:0] PowerPlusOne  = 16'sd16384;
  localparam logic signed [15:0] PowerMinusOne = -16'sd16384;

  typedef struct packed {
    logic                tick;
    logic                start;
    logic                div_step;
    logic                emit;
    logic                last;
    logic [ChanBits-1:0] ch;
  } rpd_cmd_t;

  typedef struct packed {
    logic [NumChannels-1:0] fall;
    logic                   need_div;
    logic                   div_done;
    logic                   out_free;
  } rpd_status_t;

endpackage

[sv/rpd_ctrl.sv]
// Controller that sequences the channels of one tick through the datapath.
`timescale 1ns / 1ps
module rpd_ctrl
  import rpd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  rpd_status_t status_i,
  output rpd_cmd_t    cmd_o
);

  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StScan = 4'b0010,
    StDiv  = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  state_e              state_q, state_d;
  logic [ChanBits-1:0] ch_q, ch_d;
  logic                later;

  always_comb begin
    later = 1'b0;
    for (int i = 0; i < NumChannels; i++) begin
      if (i > int'(ch_q) && status_i.fall[i]) later = 1'b1;
    end
  end

  assign in_ready_o = (state_q == StIdle);

  always_comb begin
    state_d = state_q;
    ch_d    = ch_q;
    cmd_o   = '0;
    cmd_o.ch   = ch_q;
    cmd_o.last = !later;
    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.tick = 1'b1;
          ch_d       = '0;
          state_d    = StScan;
        end
      end
      StScan: begin
        if (status_i.fall[ch_q]) begin
          cmd_o.start = 1'b1;
          state_d     = StDiv;
        end else if (!later) begin
          state_d = StIdle;
        end else begin
          ch_d = ch_q + 1'b1;
        end
      end
      StDiv: begin
        if (!status_i.need_div || status_i.div_done) begin
          state_d = StEmit;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      StEmit: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (!later) begin
            state_d = StIdle;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = StScan;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      ch_q    <= '0;
    end else begin
      state_q <= state_d;
      ch_q    <= ch_d;
    end
  end

endmodule

[sv/rpd_datapath.sv]
// Datapath with width counters, setup registers, serial divider and output register.
`timescale 1ns / 1ps
module rpd_datapath
  import rpd_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxBits-1:0]  cfg_index_i,
  input  logic [SetupBits-1:0]   cfg_data_i,
  input  logic [NumChannels-1:0] pins_i,
  input  rpd_cmd_t               cmd_i,
  output rpd_status_t            status_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [39:0]            out_data_o,
  output logic                   out_last_o
);

  logic [SetupBits-1:0]   setup_q [NumChannels];
  logic [DzBits-1:0]      dz_q;
  logic [NumChannels-1:0] prev_q, fall_q;
  logic [WidthBits-1:0]   ht_q [NumChannels];
  logic [WidthBits-1:0]   lw_q [NumChannels];
  logic signed [15:0]     cpwr_q [NumChannels];
  logic                   fs_q;

  logic signed [15:0]     pwr_q;
  logic                   need_div_q, neg_q;
  logic [WidthBits-1:0]   rem_q, dvs_q;
  logic [QuoBits-1:0]     quo_q;
  logic [DivCntBits-1:0]  cnt_q;

  logic                   ov_q, olast_q;
  logic [39:0]            odata_q;

  logic [WidthBits-1:0]   mn, zr, mx, w;
  logic                   three;
  logic [WidthBits:0]     hi_mid, lo_mid, rem2;
  logic signed [15:0]     cand, new_pwr, mag, rep;
  logic                   trip, fs_mid, fs_new;

  always_comb begin
    mn     = setup_q[cmd_i.ch][15:0];
    zr     = setup_q[cmd_i.ch][31:16];
    mx     = setup_q[cmd_i.ch][47:32];
    three  = setup_q[cmd_i.ch][48];
    w      = ht_q[cmd_i.ch];
    hi_mid = ({1'b0, mx} + {1'b0, zr}) >> 1;
    lo_mid = ({1'b0, mn} + {1'b0, zr}) >> 1;
    rem2   = {rem_q, 1'b0};
    cand   = need_div_q ? (neg_q ? -$signed({2'b00, quo_q}) : $signed({2'b00, quo_q}))
                        : pwr_q;
    trip   = (lw_q[0] == TripWidth0) && (lw_q[1] == TripWidth1) &&
             (lw_q[2] == TripWidth2) && (lw_q[3] == TripWidth3) && !fs_q;
    new_pwr = trip ? cpwr_q[cmd_i.ch] : cand;
    fs_mid  = trip | fs_q;
    fs_new  = (lw_q[3] == ReleaseWidth) ? 1'b0 : fs_mid;
    mag     = new_pwr[15] ? -new_pwr : new_pwr;
    rep     = (mag <= $signed({1'b0, dz_q})) ? 16'sd0 : new_pwr;
  end

  assign status_o.fall     = fall_q;
  assign status_o.need_div = need_div_q;
  assign status_o.div_done = (cnt_q == '0);
  assign status_o.out_free = !ov_q || out_ready_i;

  assign out_valid_o = ov_q;
  assign out_data_o  = odata_q;
  assign out_last_o  = olast_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumChannels; i++) begin
        setup_q[i] <= SetupReset;
        ht_q[i]    <= '0;
        lw_q[i]    <= '0;
        cpwr_q[i]  <= '0;
      end
      dz_q    <= DeadZoneReset;
      prev_q  <= '0;
      fall_q  <= '0;
      fs_q    <= 1'b1;
      ov_q    <= 1'b0;
      cnt_q   <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i < CfgIdxDeadZone) begin
          setup_q[cfg_index_i[ChanBits-1:0]] <= cfg_data_i;
        end else if (cfg_index_i == CfgIdxDeadZone) begin
          dz_q <= cfg_data_i[DzBits-1:0];
        end
      end
      if (cmd_i.tick) begin
        for (int i = 0; i < NumChannels; i++) begin
          if (pins_i[i] && !prev_q[i]) begin
            ht_q[i] <= '0;
          end else if (ht_q[i] != '1) begin
            ht_q[i] <= ht_q[i] + 1'b1;
          end
        end
        fall_q <= ~pins_i & prev_q;
        prev_q <= pins_i;
      end
      if (cmd_i.start) begin
        lw_q[cmd_i.ch] <= w;
        cnt_q          <= DivCntBits'(QuoBits);
      end
      if (cmd_i.div_step) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.emit) begin
        cpwr_q[cmd_i.ch] <= new_pwr;
        fs_q             <= fs_new;
      end
      if (cmd_i.emit) begin
        ov_q <= 1'b1;
      end else if (out_ready_i) begin
        ov_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      need_div_q <= 1'b0;
      neg_q      <= 1'b0;
      quo_q      <= '0;
      if (three) begin
        if ({1'b0, w} > hi_mid) pwr_q <= PowerPlusOne;
        else if ({1'b0, w} < lo_mid) pwr_q <= PowerMinusOne;
        else pwr_q <= '0;
      end else if (w > zr) begin
        if (w >= mx) begin
          pwr_q <= PowerPlusOne;
        end else begin
          need_div_q <= 1'b1;
          rem_q      <= w - zr;
          dvs_q      <= mx - zr;
        end
      end else if (w < zr) begin
        if (w <= mn) begin
          pwr_q <= PowerMinusOne;
        end else begin
          need_div_q <= 1'b1;
          neg_q      <= 1'b1;
          rem_q      <= zr - w;
          dvs_q      <= zr - mn;
        end
      end else begin
        pwr_q <= '0;
      end
    end
    if (cmd_i.div_step) begin
      if (rem2 >= {1'b0, dvs_q}) begin
        rem_q <= WidthBits'(rem2 - {1'b0, dvs_q});
        quo_q <= {quo_q[QuoBits-2:0], 1'b1};
      end else begin
        rem_q <= rem2[WidthBits-1:0];
        quo_q <= {quo_q[QuoBits-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      odata_q <= {5'b0, fs_new, rep, lw_q[cmd_i.ch], cmd_i.ch};
      olast_q <= cmd_i.last;
    end
  end

endmodule

[sv/rc_pwm_channel_decoder.sv]
// Top level of the RC PWM channel decoder.
`timescale 1ns / 1ps
// The slave stream takes one transaction per microsecond tick; tdata bits 3:0
// carry the four pin levels. For each channel whose pulse ended on that tick,
// in channel order, the master stream delivers one transaction with the
// channel index, the measured width, the deadzoned Q2.14 power and the
// failsafe flag; tlast marks the final one of the tick.
// The configuration channel writes the four channel setups (index 0 to 3)
// and the dead zone (index 4); it is always ready.
// A tick is accepted in the idle state; the scan state then steps through the
// channels up to the last one whose pulse ended, and each ended pulse passes
// through the divide and emit states, its stick ratio going through the
// bit-serial divider when needed (one quotient bit per cycle, 14 bits).
// A new tick is taken only once the previous one has been fully sequenced.
// The result waits in an output register; a stalled receiver holds the next
// result in the datapath until the register frees, and a new tick can be
// accepted while the final result is still waiting.
// Reset clears all counters and widths, restores default setups and sets
// the failsafe flag.
module rc_pwm_channel_decoder
  import rpd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [7:0]            s_axis_tdata,   // [3:0] pin_levels
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,   // [1:0] channel, [17:2] pulse_width,
                                                // [33:18] power, [34] failsafe
  output logic                  m_axis_tlast,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxBits-1:0] cfg_index_i,
  input  logic [SetupBits-1:0]  cfg_data_i
);

  rpd_cmd_t    cmd;
  rpd_status_t status;

  assign cfg_ready_o = 1'b1;

  rpd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rpd_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .pins_i      (s_axis_tdata[NumChannels-1:0]),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

endmodule
